>>> rtl/core/sssd_pkg.sv
package sssd_pkg;

    localparam int unsigned OP_W       = 2;
    localparam int unsigned DIGIT_IDX_W = 3;
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned SEG_W      = 8;
    localparam int unsigned ENABLE_W   = 6;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_TICK  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef struct packed {
        op_t                    op;
        logic [DIGIT_IDX_W-1:0] digit_index;
        logic [CHAR_W-1:0]      ascii_code;
    } req_t;

    // segment bit0 a .. bit6 g, bit7 dot
    function automatic logic [SEG_W-1:0] glyph_of(input logic [CHAR_W-1:0] code);
        logic [SEG_W-1:0] seg;
        begin
            unique case (code)
                8'h62:   seg = 8'h7C; // b
                8'h63:   seg = 8'h58; // c
                8'h64:   seg = 8'h5E; // d
                8'h68:   seg = 8'h74; // h
                8'h6E:   seg = 8'h54; // n
                8'h6F:   seg = 8'h5C; // o
                8'h72:   seg = 8'h50; // r
                8'h74:   seg = 8'h78; // t
                8'h75:   seg = 8'h1C; // u
                8'h41:   seg = 8'h77; // A
                8'h43:   seg = 8'h39; // C
                8'h45:   seg = 8'h79; // E
                8'h46:   seg = 8'h71; // F
                8'h48:   seg = 8'h76; // H
                8'h4A:   seg = 8'h0E; // J
                8'h4C:   seg = 8'h38; // L
                8'h50:   seg = 8'h73; // P
                8'h55:   seg = 8'h3E; // U
                8'h59:   seg = 8'h6E; // Y
                8'h30:   seg = 8'h3F;
                8'h31:   seg = 8'h06;
                8'h32:   seg = 8'h5B;
                8'h33:   seg = 8'h4F;
                8'h34:   seg = 8'h66;
                8'h35:   seg = 8'h6D;
                8'h36:   seg = 8'h7D;
                8'h37:   seg = 8'h07;
                8'h38:   seg = 8'h7F;
                8'h39:   seg = 8'h6F;
                8'h2D:   seg = 8'h40; // dash
                default: seg = 8'h00;
            endcase
            return seg;
        end
    endfunction

endpackage

>>> rtl/core/sssd_req_if.sv
interface sssd_req_if;
    logic                             valid;
    logic                             ready;
    logic [sssd_pkg::OP_W-1:0]        op;
    logic [sssd_pkg::DIGIT_IDX_W-1:0] digit_index;
    logic [sssd_pkg::CHAR_W-1:0]      ascii_code;

    modport source (output valid, output op, output digit_index, output ascii_code,
                    input ready);
    modport sink   (input valid, input op, input digit_index, input ascii_code,
                    output ready);
endinterface

>>> rtl/core/sssd_rsp_if.sv
interface sssd_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [sssd_pkg::ENABLE_W-1:0] digit_enable;
    logic [sssd_pkg::SEG_W-1:0]    segment_lines;

    modport source (output valid, output digit_enable, output segment_lines, input ready);
    modport sink   (input valid, input digit_enable, input segment_lines, output ready);
endinterface

>>> rtl/core/seven_segment_scan_driver.sv
// multiplexed seven-segment panel driver, one digit lit at a time
// req channel: op 0 writes the glyph of ascii_code into digit digit_index
//   (indexes of DIGITS or more are dropped), op 1 is a scan tick that
//   moves to the next digit and lights it if its pattern is not blank,
//   op 2 blanks every digit and drives all lines low, op 3 does nothing
// rsp channel: one response per request, carrying digit_enable and
//   segment_lines as they stand after that request
// path: an accepted request is held in the input register, then the
//   response register takes the pin levels
// throughput: one request per cycle while the receiver takes responses;
//   the pattern store, scan position and pin registers are all updated
//   together as the core takes a request from the input register
// reset: pattern store blank, scan position zero, all lines low, no
//   response pending
// receiver stall: the response register holds its value and one more
//   request waits in the input register; req.ready drops only when both
//   are full
module seven_segment_scan_driver #(
    parameter int unsigned DIGITS = 6
) (
    input  logic       clk,
    input  logic       rst_n,
    sssd_req_if.sink   req,
    sssd_rsp_if.source rsp
);
    import sssd_pkg::*;

    logic req_valid;
    logic req_take;
    req_t req_item;

    sssd_in_stage u_in_stage (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (req.valid),
        .in_ready       (req.ready),
        .in_op          (req.op),
        .in_digit_index (req.digit_index),
        .in_ascii_code  (req.ascii_code),
        .req_valid      (req_valid),
        .req            (req_item),
        .req_take       (req_take)
    );

    sssd_core #(
        .DIGITS (DIGITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req           (req_item),
        .req_take      (req_take),
        .out_valid     (rsp.valid),
        .out_ready     (rsp.ready),
        .digit_enable  (rsp.digit_enable),
        .segment_lines (rsp.segment_lines)
    );

endmodule

>>> rtl/core/sssd_in_stage.sv
module sssd_in_stage (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [sssd_pkg::OP_W-1:0]        in_op,
    input  logic [sssd_pkg::DIGIT_IDX_W-1:0] in_digit_index,
    input  logic [sssd_pkg::CHAR_W-1:0]      in_ascii_code,
    output logic                             req_valid,
    output sssd_pkg::req_t                   req,
    input  logic                             req_take
);
    import sssd_pkg::*;

    logic valid_reg;
    logic valid_next;
    req_t req_reg;

    assign in_ready  = !valid_reg || req_take;
    assign req_valid = valid_reg;
    assign req       = req_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (req_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg.op          <= op_t'(in_op);
            req_reg.digit_index <= in_digit_index;
            req_reg.ascii_code  <= in_ascii_code;
        end
    end

endmodule

>>> rtl/core/sssd_core.sv
module sssd_core #(
    parameter int unsigned DIGITS = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  sssd_pkg::req_t                req,
    output logic                          req_take,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sssd_pkg::ENABLE_W-1:0] digit_enable,
    output logic [sssd_pkg::SEG_W-1:0]    segment_lines
);
    import sssd_pkg::*;

    localparam int unsigned IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    logic [SEG_W-1:0]    store_reg [DIGITS];
    logic [IDX_W-1:0]    pos_reg;
    logic [IDX_W-1:0]    pos_next;
    logic [SEG_W-1:0]    seg_pins_reg;
    logic [SEG_W-1:0]    seg_pins_next;
    logic [ENABLE_W-1:0] en_pins_reg;
    logic [ENABLE_W-1:0] en_pins_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                write_hit;
    logic                clear_all;
    logic [IDX_W-1:0]    write_idx;
    logic [SEG_W-1:0]    write_glyph;
    logic [SEG_W-1:0]    next_pattern;

    assign req_take      = req_valid && (!out_valid_reg || out_ready);
    assign out_valid     = out_valid_reg;
    assign digit_enable  = en_pins_reg;
    assign segment_lines = seg_pins_reg;

    assign write_idx    = req.digit_index[IDX_W-1:0];
    assign write_glyph  = glyph_of(req.ascii_code);
    assign pos_next     = (pos_reg == IDX_W'(DIGITS - 1)) ? '0 : IDX_W'(pos_reg + 1'b1);
    assign next_pattern = store_reg[pos_next];

    always_comb
    begin
        seg_pins_next = seg_pins_reg;
        en_pins_next  = en_pins_reg;
        write_hit     = 1'b0;
        clear_all     = 1'b0;
        unique case (req.op)
            OP_WRITE:
            begin
                write_hit = ({1'b0, req.digit_index} < (DIGIT_IDX_W + 1)'(DIGITS));
            end
            OP_TICK:
            begin
                en_pins_next = en_pins_reg & ~(ENABLE_W'(1) << pos_reg);
                if (next_pattern != '0)
                begin
                    seg_pins_next = next_pattern;
                    en_pins_next  = en_pins_next | (ENABLE_W'(1) << pos_next);
                end
            end
            OP_CLEAR:
            begin
                clear_all     = 1'b1;
                seg_pins_next = '0;
                en_pins_next  = '0;
            end
            default:
            begin
                seg_pins_next = seg_pins_reg;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (req_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIGITS; i++)
            begin
                store_reg[i] <= '0;
            end
            pos_reg       <= '0;
            seg_pins_reg  <= '0;
            en_pins_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (req_take)
            begin
                seg_pins_reg <= seg_pins_next;
                en_pins_reg  <= en_pins_next;
                if (req.op == OP_TICK)
                begin
                    pos_reg <= pos_next;
                end
                if (clear_all)
                begin
                    for (int i = 0; i < DIGITS; i++)
                    begin
                        store_reg[i] <= '0;
                    end
                end
                else if (write_hit)
                begin
                    store_reg[write_idx] <= write_glyph;
                end
            end
        end
    end

    // at most one digit lit at a time
    a_one_digit_lit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(en_pins_reg))
        else $error("more than one digit enabled");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, pos_reg} < (IDX_W + 1)'(DIGITS)))
        else $error("scan position past last digit");

    // a lit digit always has a nonzero pattern on the lines
    a_lit_not_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (en_pins_reg != '0) |-> (seg_pins_reg != '0))
        else $error("digit enabled with blank segments");

    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        (req_take && req.op == OP_CLEAR) |=> (en_pins_reg == '0 && seg_pins_reg == '0))
        else $error("clear request left lines driven");

endmodule

>>> tb/testbench.sv
module testbench;

    import sssd_pkg::*;

    localparam int unsigned DIGITS = 6;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam string GLYPH_CHARS = "bcdhnortuACEFHJLPUY0123456789-";

    typedef struct packed {
        logic [ENABLE_W-1:0] digit_enable;
        logic [SEG_W-1:0]    segment_lines;
    } panel_t;

    logic clk = 1'b0;
    logic rst_n;

    sssd_req_if req_ch ();
    sssd_rsp_if rsp_ch ();

    seven_segment_scan_driver #(
        .DIGITS(DIGITS)
    ) u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    // panel state as the block should hold it
    logic [SEG_W-1:0]    glyph_store [8];
    int unsigned         scan_pos;
    logic [SEG_W-1:0]    lit_segments;
    logic [ENABLE_W-1:0] lit_enable;

    panel_t      expected_panel [$];
    int unsigned fail_count;
    bit          quiet;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [SEG_W-1:0] glyph_pattern(input logic [CHAR_W-1:0] code);
        case (code)
            "b":     return 8'h7C;
            "c":     return 8'h58;
            "d":     return 8'h5E;
            "h":     return 8'h74;
            "n":     return 8'h54;
            "o":     return 8'h5C;
            "r":     return 8'h50;
            "t":     return 8'h78;
            "u":     return 8'h1C;
            "A":     return 8'h77;
            "C":     return 8'h39;
            "E":     return 8'h79;
            "F":     return 8'h71;
            "H":     return 8'h76;
            "J":     return 8'h0E;
            "L":     return 8'h38;
            "P":     return 8'h73;
            "U":     return 8'h3E;
            "Y":     return 8'h6E;
            "0":     return 8'h3F;
            "1":     return 8'h06;
            "2":     return 8'h5B;
            "3":     return 8'h4F;
            "4":     return 8'h66;
            "5":     return 8'h6D;
            "6":     return 8'h7D;
            "7":     return 8'h07;
            "8":     return 8'h7F;
            "9":     return 8'h6F;
            "-":     return 8'h40;
            default: return 8'h00;
        endcase
    endfunction

    function automatic void reset_panel();
        foreach (glyph_store[i])
            glyph_store[i] = '0;
        scan_pos     = 0;
        lit_segments = '0;
        lit_enable   = '0;
    endfunction

    function automatic void update_panel(input logic [OP_W-1:0] op,
                                         input logic [DIGIT_IDX_W-1:0] idx,
                                         input logic [CHAR_W-1:0] code);
        panel_t pins;
        if (op == OP_WRITE) begin
            if (idx < DIGITS)
                glyph_store[idx] = glyph_pattern(code);
        end
        else if (op == OP_TICK) begin
            lit_enable = lit_enable & ~(ENABLE_W'(1) << scan_pos);
            scan_pos = (scan_pos >= DIGITS - 1) ? 0 : scan_pos + 1;
            if (glyph_store[scan_pos[DIGIT_IDX_W-1:0]] != '0) begin
                lit_segments = glyph_store[scan_pos[DIGIT_IDX_W-1:0]];
                lit_enable   = lit_enable | (ENABLE_W'(1) << scan_pos);
            end
        end
        else if (op == OP_CLEAR) begin
            foreach (glyph_store[i])
                glyph_store[i] = '0;
            lit_segments = '0;
            lit_enable   = '0;
        end
        pins.digit_enable  = lit_enable;
        pins.segment_lines = lit_segments;
        expected_panel.push_back(pins);
    endfunction

    task automatic send_request(input logic [OP_W-1:0] op,
                                input logic [DIGIT_IDX_W-1:0] idx,
                                input logic [CHAR_W-1:0] code);
        int unsigned gap;
        if (!quiet && $urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(17, 1);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.op          <= op;
        req_ch.digit_index <= idx;
        req_ch.ascii_code  <= code;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        update_panel(op, idx, code);
    endtask

    task automatic random_request();
        int unsigned r;
        logic [DIGIT_IDX_W-1:0] idx;
        logic [CHAR_W-1:0] code;
        r    = $urandom_range(99);
        idx  = DIGIT_IDX_W'($urandom_range(7));
        code = CHAR_W'($urandom_range(255));
        if (r < 46) begin
            if ($urandom_range(9) != 0)
                idx = DIGIT_IDX_W'($urandom_range(DIGITS - 1));
            if ($urandom_range(3) != 0)
                code = GLYPH_CHARS[$urandom_range(GLYPH_CHARS.len() - 1)];
            send_request(OP_WRITE, idx, code);
        end
        else if (r < 94)
            send_request(OP_TICK, idx, code);
        else if (r < 97)
            send_request(OP_CLEAR, idx, code);
        else
            send_request(OP_UNUSED, idx, code);
    endtask

    task automatic test_blank_scan();
        send_request(OP_TICK, 3'd0, 8'h00);
        send_request(OP_TICK, 3'd7, 8'hFF);
    endtask

    task automatic test_write_extremes();
        send_request(OP_WRITE, 3'd0, 8'h00);
        send_request(OP_WRITE, 3'd5, 8'hFF);
        send_request(OP_WRITE, 3'd6, "8");
        send_request(OP_WRITE, 3'd7, "8");
        send_request(OP_WRITE, 3'd5, "8");
        send_request(OP_WRITE, 3'd3, "-");
        send_request(OP_WRITE, 3'd0, "A");
    endtask

    task automatic test_scan_wrap();
        // lit, blank keeping segments, lit, wrap to digit zero
        repeat (6)
            send_request(OP_TICK, 3'd0, 8'h00);
    endtask

    task automatic test_write_while_shown();
        send_request(OP_WRITE, 3'd0, "t");
        send_request(OP_WRITE, 3'd1, 8'h80);
        send_request(OP_TICK, 3'd0, 8'h00);
    endtask

    task automatic test_clear_all();
        send_request(OP_CLEAR, 3'd7, 8'hFF);
        send_request(OP_TICK, 3'd0, 8'h00);
    endtask

    task automatic test_unused_op();
        send_request(OP_WRITE, 3'd2, "9");
        send_request(OP_UNUSED, 3'd2, 8'h00);
        send_request(OP_TICK, 3'd0, 8'h00);
        send_request(OP_UNUSED, 3'd7, 8'hFF);
    endtask

    task automatic test_random_traffic(input int unsigned count);
        for (int unsigned n = 0; n < count; n++) begin
            if (n % 64 == 0) begin
                case ($urandom_range(3))
                    0: send_idle_pct = 0;
                    1: send_idle_pct = 8;
                    2: send_idle_pct = 25;
                    default: send_idle_pct = 50;
                endcase
                case ($urandom_range(3))
                    0: recv_idle_pct = 0;
                    1: recv_idle_pct = 8;
                    2: recv_idle_pct = 25;
                    default: recv_idle_pct = 50;
                endcase
            end
            random_request();
        end
    endtask

    task automatic test_back_to_back(input int unsigned count);
        quiet = 1'b1;
        repeat (count)
            random_request();
    endtask

    // response stalls
    initial
    begin
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (!quiet && $urandom_range(99) < recv_idle_pct) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(17, 1)) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        panel_t want;
        panel_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got.digit_enable  = rsp_ch.digit_enable;
            got.segment_lines = rsp_ch.segment_lines;
            if (expected_panel.size() == 0) begin
                if (fail_count < 10)
                    $display("unexpected response: enable %h segments %h",
                             got.digit_enable, got.segment_lines);
                fail_count++;
            end
            else begin
                want = expected_panel.pop_front();
                if (got !== want) begin
                    if (fail_count < 10)
                        $display("mismatch: enable exp %h got %h, segments exp %h got %h",
                                 want.digit_enable, got.digit_enable,
                                 want.segment_lines, got.segment_lines);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.op          = '0;
        req_ch.digit_index = '0;
        req_ch.ascii_code  = '0;
        fail_count         = 0;
        quiet              = 1'b0;
        send_idle_pct      = 20;
        recv_idle_pct      = 20;
        reset_panel();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_blank_scan();
        test_write_extremes();
        test_scan_wrap();
        test_write_while_shown();
        test_clear_all();
        test_unused_op();
        test_random_traffic(1300);
        test_back_to_back(200);

        req_ch.valid <= 1'b0;
        while (expected_panel.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
rtl/core/sssd_pkg.sv
rtl/core/sssd_req_if.sv
rtl/core/sssd_rsp_if.sv
rtl/core/sssd_in_stage.sv
rtl/core/sssd_core.sv
rtl/core/seven_segment_scan_driver.sv
tb/testbench.sv
